/* hw/rtl/sdtl_pkg.sv */
// Package for the sorted date table lookup core.
// Holds payload structs, command codes and sizing constants; no dependencies.
package sdtl_pkg;

	localparam int MAX_ENTRIES_DEF = 1024;
	localparam int INDEX_W = 10;
	localparam int KEY_W = 27;
	localparam int OFFSET_W = 16;
	localparam int COUNT_W = 11;
	localparam int QUEUE_DEPTH = 2;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	typedef struct packed {
		logic command;
		logic [INDEX_W-1:0] entry_index;
		logic [KEY_W-1:0] date_key;
		logic [OFFSET_W-1:0] name_offset;
	} in_t;

	typedef struct packed {
		logic found;
		logic [OFFSET_W-1:0] found_offset;
	} out_t;

	typedef struct packed {
		logic lookup;
		logic addr_ok;
		logic [INDEX_W-1:0] index;
		logic [KEY_W-1:0] key;
		logic [OFFSET_W-1:0] offset;
	} op_t;

	typedef struct packed {
		logic valid;
		logic ready;
	} hs_t;

	typedef struct packed {
		logic busy;
	} status_t;

endpackage

/* hw/rtl/sorted_date_table_lookup_core.sv */
// Sorted date table lookup core: a front queue feeding a binary search engine.
// A load is written to the table as it leaves the queue, and the engine stays idle; a lookup
// runs a range check against the first and last entries, then a binary search whose table
// probes all use the single table read port, and its result goes to the output register.
// One transaction is worked on at a time while up to two more wait in the queue.
// Reset clears control state and the entry count; table contents stay undefined until loaded.
module sorted_date_table_lookup_core #(
	parameter int MAX_ENTRIES = sdtl_pkg::MAX_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sdtl_pkg::in_t in_item,
	output logic out_valid,
	input  logic out_ready,
	output sdtl_pkg::out_t out_item,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [sdtl_pkg::COUNT_W-1:0] cfg_data
);

	logic [sdtl_pkg::COUNT_W-1:0] entry_count_q;
	sdtl_pkg::hs_t q_hs;
	logic q_pop_ready;
	sdtl_pkg::op_t q_op;
	sdtl_pkg::status_t back_status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			entry_count_q <= cfg_data;
		end
	end

	sdtl_front #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.q_hs_o(q_hs),
		.q_pop_ready(q_pop_ready),
		.q_op(q_op)
	);

	sdtl_back #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.entry_count(entry_count_q),
		.q_valid(q_hs.valid),
		.q_ready(q_pop_ready),
		.q_op(q_op),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.status(back_status)
	);

	a_miss_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.found |-> out_item.found_offset == '0)
		else $error("A miss carries a nonzero offset.");

	a_accept_fills_queue: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> q_hs.valid)
		else $error("An accepted transaction did not reach the queue.");

	a_result_from_engine: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(back_status.busy))
		else $error("A result appeared while the engine was idle.");

	a_idle_pops: assert property (@(posedge clk) disable iff (!arst_n)
		q_hs.ready |-> !back_status.busy)
		else $error("The queue was popped while the engine was busy.");

endmodule

/* hw/rtl/sdtl_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sdtl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/sdtl_front.sv */
// Front end: accepts input transactions, classifies them and queues them.
// Depends on sdtl_pkg.
module sdtl_front #(
	parameter int MAX_ENTRIES = sdtl_pkg::MAX_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sdtl_pkg::in_t in_item,
	output sdtl_pkg::hs_t q_hs_o,
	input  logic q_pop_ready,
	output sdtl_pkg::op_t q_op
);

	localparam int QPW = (sdtl_pkg::QUEUE_DEPTH > 1) ? $clog2(sdtl_pkg::QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(sdtl_pkg::QUEUE_DEPTH + 1);

	sdtl_pkg::op_t slot_q [sdtl_pkg::QUEUE_DEPTH];
	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QCW-1:0] cnt_q;
	sdtl_pkg::op_t op_in;
	logic push;
	logic pop;

	always_comb begin
		op_in.lookup = (in_item.command == sdtl_pkg::CMD_LOOKUP);
		op_in.addr_ok = (32'(in_item.entry_index) < MAX_ENTRIES);
		op_in.index = in_item.entry_index;
		op_in.key = in_item.date_key;
		op_in.offset = in_item.name_offset;
	end

	assign in_ready = (cnt_q != QCW'(sdtl_pkg::QUEUE_DEPTH));
	assign push = in_valid && in_ready;
	assign q_hs_o.valid = (cnt_q != '0);
	assign q_hs_o.ready = q_pop_ready;
	assign pop = q_hs_o.valid && q_pop_ready;
	assign q_op = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= op_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPW'(sdtl_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPW'(sdtl_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/sdtl_back.sv */
// Back end: writes table entries and runs the range check and binary search.
// Depends on sdtl_pkg and sdtl_ram.
module sdtl_back #(
	parameter int MAX_ENTRIES = sdtl_pkg::MAX_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [sdtl_pkg::COUNT_W-1:0] entry_count,
	input  logic q_valid,
	output logic q_ready,
	input  sdtl_pkg::op_t q_op,
	output logic out_valid,
	input  logic out_ready,
	output sdtl_pkg::out_t out_item,
	output sdtl_pkg::status_t status
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int NW = $clog2(MAX_ENTRIES + 1);
	localparam int WW = sdtl_pkg::KEY_W + sdtl_pkg::OFFSET_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CHK0 = 3'd1;
	localparam logic [2:0] S_CHKN = 3'd2;
	localparam logic [2:0] S_PROBE = 3'd3;
	localparam logic [2:0] S_FINAL = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0] state_q;
	logic [sdtl_pkg::KEY_W-1:0] key_q;
	logic [NW-1:0] lo_q;
	logic [NW-1:0] hi_q;
	logic [NW-1:0] mid_q;
	logic res_found_q;
	logic [sdtl_pkg::OFFSET_W-1:0] res_off_q;
	logic out_valid_q;
	sdtl_pkg::out_t out_q;

	logic [NW-1:0] n;
	logic [NW-1:0] lo_n;
	logic [NW-1:0] hi_n;
	logic [NW-1:0] mid_n;
	logic less;
	logic ram_we;
	logic [AW-1:0] raddr;
	logic [WW-1:0] rdata;
	logic [sdtl_pkg::KEY_W-1:0] rd_key;
	logic [sdtl_pkg::OFFSET_W-1:0] rd_off;
	logic slot_free;

	assign n = (32'(entry_count) > MAX_ENTRIES) ? NW'(MAX_ENTRIES) : NW'(entry_count);
	assign rd_key = rdata[WW-1:sdtl_pkg::OFFSET_W];
	assign rd_off = rdata[sdtl_pkg::OFFSET_W-1:0];
	assign less = (rd_key < key_q);
	assign lo_n = less ? mid_q + 1'b1 : lo_q;
	assign hi_n = less ? hi_q : mid_q;
	assign mid_n = lo_n + ((hi_n - lo_n) >> 1);
	assign q_ready = (state_q == S_IDLE);
	assign ram_we = q_ready && q_valid && !q_op.lookup && q_op.addr_ok;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_item = out_q;
	assign status.busy = (state_q != S_IDLE);

	always_comb begin
		unique case (state_q)
			S_CHK0: raddr = AW'(n - 1'b1);
			S_CHKN: raddr = AW'(n >> 1);
			S_PROBE: raddr = (lo_n < hi_n) ? AW'(mid_n) : AW'(lo_n);
			default: raddr = '0;
		endcase
	end

	sdtl_ram #(
		.WIDTH(WW),
		.DEPTH(MAX_ENTRIES)
	) u_table (
		.clk(clk),
		.we(ram_we),
		.waddr(AW'(q_op.index)),
		.wdata({q_op.key, q_op.offset}),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				key_q <= q_op.key;
				res_found_q <= 1'b0;
				res_off_q <= '0;
			end
			S_CHKN: begin
				lo_q <= '0;
				hi_q <= n;
				mid_q <= n >> 1;
			end
			S_PROBE: begin
				lo_q <= lo_n;
				hi_q <= hi_n;
				mid_q <= mid_n;
			end
			S_FINAL: begin
				res_found_q <= (rd_key == key_q);
				res_off_q <= (rd_key == key_q) ? rd_off : '0;
			end
			default: begin
			end
		endcase
		if (state_q == S_DONE && slot_free) begin
			out_q.found <= res_found_q;
			out_q.found_offset <= res_off_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid && q_op.lookup) begin
						state_q <= (n == '0) ? S_DONE : S_CHK0;
					end
				end
				S_CHK0: begin
					state_q <= (key_q < rd_key) ? S_DONE : S_CHKN;
				end
				S_CHKN: begin
					state_q <= (key_q > rd_key) ? S_DONE : S_PROBE;
				end
				S_PROBE: begin
					if (lo_n < hi_n) begin
						state_q <= S_PROBE;
					end else if (lo_n >= n) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_FINAL;
					end
				end
				S_FINAL: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
